// ===== sv/chb_pkg.sv =====
// chb_pkg: shared types and codes for the canonical huffman encoder
// payload structs for command and result transactions, opcodes, sequencer states
// no dependencies

package chb_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_ENCODE = 2'd2,
        OP_FLUSH  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
        logic [4:0] code_length;
    } cmd_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_of_run;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_EMIT,
        ST_CNT,
        ST_BASE,
        ST_ASSIGN
    } state_t;

endpackage

// ===== sv/canonical_huffman_encoder_core.sv =====
// canonical_huffman_encoder_core: length table, canonical code build and lsb-first byte packer
// depends on chb_pkg and chb_ram
//
// channel  signals                      direction  payload
// cmd      cmd_valid / cmd_ready / cmd  in         chb_pkg::cmd_t (opcode, symbol, code_length)
// res      res_valid / res_ready / res  out        chb_pkg::res_t (packed_byte, last_of_run)
//
// load completes on acceptance, encode reads the tables, packs in ST_ENC and sends each full byte
// from ST_EMIT, flush sends a held partial byte from ST_EMIT; one transaction is in flight at a time
// build runs two sweeps over the length ram with a base pass between them (ST_CNT, ST_BASE,
// ST_ASSIGN), paced by the single read port of the length ram
// length entries are cleared at reset by per-symbol valid flops, no clearing pass
// a stalled res holds the emitter and keeps cmd_ready low

module canonical_huffman_encoder_core #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  chb_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output chb_pkg::res_t res
);

    localparam int IDX_W  = $clog2(NUM_SYMBOLS);
    localparam int SC_W   = $clog2(NUM_SYMBOLS + 1);
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CODE_W = MAX_CODE_LEN;
    localparam int WIDE_W = MAX_CODE_LEN + 8;
    localparam int TOT_W  = $clog2(MAX_CODE_LEN + 8);
    localparam int NB_W   = $clog2((MAX_CODE_LEN + 7) / 8 + 1);

    chb_pkg::state_t   state_reg, state_next;

    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [SC_W-1:0]   sc_reg, sc_next;
    logic              dv_reg, dv_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [CODE_W-1:0] sum_reg, sum_next;
    logic [CODE_W-1:0] arr_reg [1:MAX_CODE_LEN];
    logic [CODE_W-1:0] arr_next [1:MAX_CODE_LEN];
    logic [WIDE_W-1:0] wide_reg, wide_next;
    logic [NB_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic [7:0]        pbyte_reg, pbyte_next;
    logic [2:0]        pbits_reg, pbits_next;
    logic [NUM_SYMBOLS-1:0] vld_reg;

    logic              accept;
    logic              in_range;
    logic              issue;
    logic [IDX_W-1:0]  rd_addr;
    logic              len_we;
    logic [LEN_W-1:0]  len_wdata;
    logic [LEN_W-1:0]  len_q;
    logic [LEN_W-1:0]  len_rd;
    logic              code_we;
    logic [CODE_W-1:0] code_wdata;
    logic [CODE_W-1:0] code_q;
    logic [CODE_W-1:0] code_m;
    logic [TOT_W-1:0]  total;
    logic [WIDE_W-1:0] wide;
    logic [NB_W-1:0]   nbytes;

    assign accept   = cmd_valid && cmd_ready;
    assign in_range = {1'b0, cmd.symbol} < 9'(NUM_SYMBOLS);
    assign issue    = sc_reg < SC_W'(NUM_SYMBOLS);

    // length read through valid bits, code masked to its length
    assign len_rd = vld_reg[addr_reg] ? len_q : '0;
    assign code_m = code_q & ~({CODE_W{1'b1}} << len_rd);
    assign total  = TOT_W'(pbits_reg) + TOT_W'(len_rd);
    assign wide   = WIDE_W'(pbyte_reg) | (WIDE_W'(code_m) << pbits_reg);
    assign nbytes = NB_W'(total >> 3);

    assign len_wdata = (cmd.code_length > 5'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                            : LEN_W'(cmd.code_length);

    chb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (cmd.symbol[IDX_W-1:0]),
        .wdata (len_wdata),
        .raddr (rd_addr),
        .rdata (len_q)
    );

    chb_ram #(
        .WIDTH (CODE_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr (addr_reg),
        .wdata (code_wdata),
        .raddr (rd_addr),
        .rdata (code_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.opcode)
                        chb_pkg::OP_LOAD:   state_next = chb_pkg::ST_IDLE;
                        chb_pkg::OP_BUILD:  state_next = chb_pkg::ST_CNT;
                        chb_pkg::OP_ENCODE: state_next = in_range ? chb_pkg::ST_ENC
                                                                  : chb_pkg::ST_IDLE;
                        chb_pkg::OP_FLUSH:  state_next = (pbits_reg != '0) ? chb_pkg::ST_EMIT
                                                                           : chb_pkg::ST_IDLE;
                        default:            state_next = chb_pkg::ST_IDLE;
                    endcase
                end
            end
            chb_pkg::ST_ENC:
            begin
                state_next = (nbytes != '0) ? chb_pkg::ST_EMIT : chb_pkg::ST_IDLE;
            end
            chb_pkg::ST_EMIT:
            begin
                if (res_ready && emit_cnt_reg == NB_W'(1))
                begin
                    state_next = chb_pkg::ST_IDLE;
                end
            end
            chb_pkg::ST_CNT:
            begin
                if (!issue && !dv_reg)
                begin
                    state_next = chb_pkg::ST_BASE;
                end
            end
            chb_pkg::ST_BASE:
            begin
                if (k_reg == LEN_W'(MAX_CODE_LEN))
                begin
                    state_next = chb_pkg::ST_ASSIGN;
                end
            end
            chb_pkg::ST_ASSIGN:
            begin
                if (!issue && !dv_reg)
                begin
                    state_next = chb_pkg::ST_IDLE;
                end
            end
            default: state_next = chb_pkg::ST_IDLE;
        endcase
    end

    // handshake and ram controls
    always_comb
    begin
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;
        res.packed_byte = wide_reg[7:0];
        res.last_of_run = (emit_cnt_reg == NB_W'(1));
        rd_addr         = sc_reg[IDX_W-1:0];
        len_we          = 1'b0;
        code_we         = 1'b0;
        code_wdata      = '0;
        unique case (state_reg)
            chb_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                rd_addr   = cmd.symbol[IDX_W-1:0];
                len_we    = accept && (cmd.opcode == chb_pkg::OP_LOAD) && in_range;
            end
            chb_pkg::ST_EMIT:
            begin
                res_valid = 1'b1;
            end
            chb_pkg::ST_CNT:
            begin
                code_we = dv_reg && (len_rd == '0);
            end
            chb_pkg::ST_ASSIGN:
            begin
                code_we    = dv_reg && (len_rd != '0);
                code_wdata = arr_reg[len_rd];
            end
            default:
            begin
                code_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        addr_next     = addr_reg;
        sc_next       = sc_reg;
        dv_next       = 1'b0;
        k_next        = k_reg;
        sum_next      = sum_reg;
        arr_next      = arr_reg;
        wide_next     = wide_reg;
        emit_cnt_next = emit_cnt_reg;
        pbyte_next    = pbyte_reg;
        pbits_next    = pbits_reg;
        unique case (state_reg)
            chb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = cmd.symbol[IDX_W-1:0];
                    case (cmd.opcode)
                        chb_pkg::OP_BUILD:
                        begin
                            sc_next  = '0;
                            k_next   = LEN_W'(1);
                            sum_next = '0;
                            for (int i = 1; i <= MAX_CODE_LEN; i++)
                            begin
                                arr_next[i] = '0;
                            end
                        end
                        chb_pkg::OP_FLUSH:
                        begin
                            if (pbits_reg != '0)
                            begin
                                wide_next     = WIDE_W'(pbyte_reg);
                                emit_cnt_next = NB_W'(1);
                            end
                            pbyte_next = '0;
                            pbits_next = '0;
                        end
                        default:
                        begin
                            addr_next = cmd.symbol[IDX_W-1:0];
                        end
                    endcase
                end
            end
            chb_pkg::ST_ENC:
            begin
                pbits_next = total[2:0];
                if (nbytes == '0)
                begin
                    pbyte_next = wide[7:0];
                end
                else
                begin
                    wide_next     = wide;
                    emit_cnt_next = nbytes;
                end
            end
            chb_pkg::ST_EMIT:
            begin
                if (res_ready)
                begin
                    wide_next     = wide_reg >> 8;
                    emit_cnt_next = emit_cnt_reg - NB_W'(1);
                    if (emit_cnt_reg == NB_W'(1))
                    begin
                        pbyte_next = wide_reg[15:8];
                    end
                end
            end
            chb_pkg::ST_CNT:
            begin
                sc_next   = issue ? sc_reg + SC_W'(1) : sc_reg;
                dv_next   = issue;
                addr_next = sc_reg[IDX_W-1:0];
                if (dv_reg && len_rd != '0)
                begin
                    arr_next[len_rd] = arr_reg[len_rd] + CODE_W'(1);
                end
            end
            chb_pkg::ST_BASE:
            begin
                // first code of each length from the counts
                arr_next[k_reg] = sum_reg << 1;
                sum_next        = (sum_reg << 1) + arr_reg[k_reg];
                k_next          = k_reg + LEN_W'(1);
                if (k_reg == LEN_W'(MAX_CODE_LEN))
                begin
                    sc_next = '0;
                end
            end
            chb_pkg::ST_ASSIGN:
            begin
                sc_next   = issue ? sc_reg + SC_W'(1) : sc_reg;
                dv_next   = issue;
                addr_next = sc_reg[IDX_W-1:0];
                if (dv_reg && len_rd != '0)
                begin
                    arr_next[len_rd] = arr_reg[len_rd] + CODE_W'(1);
                end
            end
            default:
            begin
                dv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= chb_pkg::ST_IDLE;
            dv_reg       <= 1'b0;
            sc_reg       <= '0;
            k_reg        <= '0;
            emit_cnt_reg <= '0;
            pbyte_reg    <= '0;
            pbits_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dv_reg       <= dv_next;
            sc_reg       <= sc_next;
            k_reg        <= k_next;
            emit_cnt_reg <= emit_cnt_next;
            pbyte_reg    <= pbyte_next;
            pbits_reg    <= pbits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        sum_reg  <= sum_next;
        arr_reg  <= arr_next;
        wide_reg <= wide_next;
    end

    // valid bits stand in for the cleared length table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (len_we)
        begin
            vld_reg[cmd.symbol[IDX_W-1:0]] <= 1'b1;
        end
    end

endmodule

// ===== sv/chb_ram.sv =====
// chb_ram: generic simple dual port ram, one write port, one registered read port
// depends on nothing

module chb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
